[hdl/sei_caption_detector_defines.svh]
// Assertion helpers used by the top-level detector to check this block.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef SEI_CAPTION_DETECTOR_DEFINES_SVH
`define SEI_CAPTION_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SEI_CAP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SEI_CAP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sei_cap_pkg.sv]
package sei_cap_pkg;

  // Field widths of the request and result channels.
  localparam int DATA_W     = 8;
  localparam int NAL_LEN_W  = 24;
  localparam int OUTCOME_W  = 3;
  localparam int HDR_W      = 3;
  localparam int TYPE_W     = 16;

  // Default width of the length counters.
  localparam int LEN_BITS_DEF = 24;

  // Reset value of the header byte count (one byte for AVC).
  localparam logic [HDR_W-1:0] HDR_BYTES_RST = 3'd1;

  // GA94 signature length and the minimum raw budget to start a message.
  localparam int SIG_LEN     = 7;
  localparam int MIN_MSG_RAW = SIG_LEN + 2;

  // Registered user data payload type.
  localparam logic [TYPE_W-1:0] SEI_TYPE_USER_DATA = 16'd4;

  localparam logic [DATA_W-1:0] BYTE_EXT = 8'hff;
  localparam logic [DATA_W-1:0] BYTE_EPB = 8'h03;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OUTC_FOUND     = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUTC_NONE      = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUTC_HDR_FAIL  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUTC_TYPE_FAIL = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUTC_SIZE_FAIL = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUTC_PAY_FAIL  = 3'd5;

  // Result handed from the parser to the output register.
  typedef struct packed {
    logic                 valid;
    logic                 captions_found;
    logic [OUTCOME_W-1:0] outcome;
  } sei_cap_result_t;

  // Expected GA94 signature byte at a payload position.
  function automatic logic [DATA_W-1:0] ga94_sig_byte(input logic [2:0] pos);
    logic [DATA_W-1:0] val;
    case (pos)
      3'd0: val = 8'hb5;
      3'd1: val = 8'h00;
      3'd2: val = 8'h31;
      3'd3: val = 8'h47;
      3'd4: val = 8'h41;
      3'd5: val = 8'h39;
      3'd6: val = 8'h34;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[hdl/sei_cap_if.sv]
// Byte request channel into the detector.
interface sei_cap_in_if import sei_cap_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    data_byte;
  logic                 first_byte;
  logic                 end_of_data;
  logic [NAL_LEN_W-1:0] nal_length;

  modport source (output valid, data_byte, first_byte, end_of_data, nal_length,
                  input ready);
  modport sink (input valid, data_byte, first_byte, end_of_data, nal_length,
                output ready);
endinterface

// Result channel out of the detector.
interface sei_cap_out_if import sei_cap_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 captions_found;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, captions_found, outcome, input ready);
  modport sink (input valid, captions_found, outcome, output ready);
endinterface

[hdl/sei_caption_detector.sv]
// SEI caption detector: takes the raw bytes of one H.264 or HEVC SEI NAL unit,
// one byte per request, drops emulation-prevention bytes, walks the SEI
// messages and gives one result per NAL: captions found when a registered
// user data payload opens with the GA94 signature, otherwise no captions or
// the stage at which parsing stopped. It takes one byte every cycle; a result
// appears in the cycle after the byte that decides it, and the input stalls
// only while a finished result waits to be taken; the per-byte update of the
// parser registers sets that rate. The user must write the header byte count
// on the cfg port while no NAL is being parsed; the block does not enforce it.
`include "sei_caption_detector_defines.svh"

module sei_caption_detector import sei_cap_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [HDR_W-1:0] cfg_wr_data,
  sei_cap_in_if.sink       in_chan,
  sei_cap_out_if.source    out_chan
);

  sei_cap_result_t core_res;
  logic            accept_ok;
  logic            in_fire;

  // Byte parser and message state.
  sei_cap_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .accept_ok   (accept_ok),
    .res         (core_res)
  );

  // Result register toward the consumer.
  sei_cap_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (core_res),
    .accept_ok (accept_ok),
    .out_chan  (out_chan)
  );

  assign in_fire = in_chan.valid && in_chan.ready;

  // A decided byte always shows a result in the next cycle.
  `SEI_CAP_ASSERT_NXT(a_result_shown, in_fire && core_res.valid, out_chan.valid,
                      "decided result was not shown")
  // The captions flag agrees with the outcome code.
  `SEI_CAP_ASSERT_IMP(a_flag_matches, out_chan.valid,
                      out_chan.captions_found == (out_chan.outcome == OUTC_FOUND),
                      "captions flag disagrees with outcome")
  // The input stalls only behind a held result.
  `SEI_CAP_ASSERT_IMP(a_stall_cause, !in_chan.ready, out_chan.valid && !out_chan.ready,
                      "input stalled with no held result")

endmodule

[hdl/sei_cap_parser.sv]
module sei_cap_parser import sei_cap_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [HDR_W-1:0] cfg_wr_data,
  sei_cap_in_if.sink       in_chan,
  input  logic             accept_ok,
  output sei_cap_result_t  res
);

  // Parser phases.
  localparam logic [2:0] PH_DONE = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_SIZE = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;

  localparam logic [2:0] SIG_END = 3'(SIG_LEN);

  logic [HDR_W-1:0]    header_bytes_r;
  logic [2:0]          phase_r, phase_nxt;
  logic [LEN_BITS-1:0] raw_left_r, raw_left_nxt;
  logic [1:0]          zero_run_r, zero_run_nxt;
  logic [LEN_BITS-1:0] skip_r, skip_nxt;
  logic [TYPE_W-1:0]   type_sum_r, type_sum_nxt;
  logic [LEN_BITS-1:0] size_sum_r, size_sum_nxt;
  logic [2:0]          match_pos_r, match_pos_nxt;
  logic                match_good_r, match_good_nxt;
  logic [LEN_BITS-1:0] slack_r, slack_nxt;

  logic                  fire;
  logic [DATA_W-1:0]     b;
  logic                  res_valid;
  logic [OUTCOME_W-1:0]  res_code;

  logic [LEN_BITS-1:0] len_w, hb_w, len_minus_hb, len_minus_2;
  logic                len_lt_hb, len_ge9, len_ge10;
  logic [LEN_BITS-1:0] raw_dec;
  logic                raw_zero, raw_ge9;
  logic [TYPE_W:0]     type_add;
  logic [TYPE_W-1:0]   type_new;
  logic                type_is_ud;
  logic [LEN_BITS:0]   size_add, pay_diff;
  logic [LEN_BITS-1:0] size_new, slack_new;
  logic                size_ge_sig, pay_fail;
  logic [LEN_BITS-1:0] skip_dec;
  logic                skip_one;
  logic                esc;
  logic [1:0]          zr_step;
  logic                sig_open;
  logic                mg_pay;
  logic [2:0]          mp_pay;

  // Failure stage reported for a phase.
  function automatic logic [OUTCOME_W-1:0] stage_code(input logic [2:0] ph);
    logic [OUTCOME_W-1:0] code;
    case (ph)
      PH_HEAD: code = OUTC_HDR_FAIL;
      PH_TYPE: code = OUTC_TYPE_FAIL;
      PH_SIZE: code = OUTC_SIZE_FAIL;
      default: code = OUTC_PAY_FAIL;
    endcase
    return code;
  endfunction

  assign in_chan.ready = accept_ok;
  assign fire = in_chan.valid && accept_ok;
  assign b    = in_chan.data_byte;

  // Length checks for a new NAL, all taken against the sampled length.
  assign len_w        = LEN_BITS'(in_chan.nal_length);
  assign hb_w         = LEN_BITS'(header_bytes_r);
  assign len_lt_hb    = len_w < hb_w;
  assign len_ge9      = len_w >= LEN_BITS'(MIN_MSG_RAW);
  assign len_ge10     = len_w >= LEN_BITS'(MIN_MSG_RAW + 1);
  assign len_minus_hb = len_w - hb_w;
  assign len_minus_2  = len_w - LEN_BITS'(2);

  // Budget of the open NAL.
  assign raw_dec  = raw_left_r - LEN_BITS'(1);
  assign raw_zero = raw_left_r == '0;
  assign raw_ge9  = raw_left_r >= LEN_BITS'(MIN_MSG_RAW);

  // Saturating type and size sums.
  assign type_add   = {1'b0, type_sum_r} + (TYPE_W+1)'(b);
  assign type_new   = type_add[TYPE_W] ? '1 : type_add[TYPE_W-1:0];
  assign type_is_ud = type_sum_r == SEI_TYPE_USER_DATA;
  assign size_add   = {1'b0, size_sum_r} + (LEN_BITS+1)'(b);
  assign size_new   = size_add[LEN_BITS] ? '1 : size_add[LEN_BITS-1:0];

  // Payload budget check and signature slack.
  assign pay_diff    = {1'b0, raw_left_r} - {1'b0, size_new};
  assign pay_fail    = pay_diff[LEN_BITS];
  assign size_ge_sig = size_new >= LEN_BITS'(SIG_LEN);
  assign slack_new   = size_new - LEN_BITS'(SIG_LEN);

  assign skip_dec = skip_r - LEN_BITS'(1);
  assign skip_one = skip_r == LEN_BITS'(1);

  // Emulation-prevention detection and zero run tracking.
  assign esc     = (zero_run_r == 2'd2) && (b == BYTE_EPB);
  assign zr_step = esc ? 2'd0 :
                   (b == '0) ? ((zero_run_r < 2'd2) ? zero_run_r + 2'd1 : 2'd2) : 2'd0;

  // Signature compare on the current payload byte.
  assign sig_open = match_pos_r < SIG_END;
  assign mg_pay   = match_good_r && (!sig_open || (b == ga94_sig_byte(match_pos_r)));
  assign mp_pay   = sig_open ? match_pos_r + 3'd1 : match_pos_r;

  // Next state and result for one accepted byte.
  always_comb begin
    phase_nxt      = phase_r;
    raw_left_nxt   = raw_left_r;
    zero_run_nxt   = zero_run_r;
    skip_nxt       = skip_r;
    type_sum_nxt   = type_sum_r;
    size_sum_nxt   = size_sum_r;
    match_pos_nxt  = match_pos_r;
    match_good_nxt = match_good_r;
    slack_nxt      = slack_r;
    res_valid      = 1'b0;
    res_code       = OUTC_NONE;

    if (fire) begin
      if (in_chan.first_byte) begin
        // New NAL: header skip and the first byte are folded together.
        zero_run_nxt = (b == '0) ? 2'd1 : 2'd0;
        if (len_lt_hb) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res_code  = OUTC_HDR_FAIL;
        end else if (header_bytes_r == '0) begin
          if (!len_ge9) begin
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            res_code  = OUTC_NONE;
          end else begin
            type_sum_nxt = TYPE_W'(b);
            size_sum_nxt = '0;
            raw_left_nxt = len_minus_2;
            phase_nxt    = (b == BYTE_EXT) ? PH_TYPE : PH_SIZE;
          end
        end else if (header_bytes_r == 3'd1) begin
          if (!len_ge10) begin
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            res_code  = OUTC_NONE;
          end else begin
            phase_nxt    = PH_TYPE;
            type_sum_nxt = '0;
            raw_left_nxt = len_minus_2;
          end
        end else begin
          phase_nxt    = PH_HEAD;
          raw_left_nxt = len_minus_hb;
          skip_nxt     = LEN_BITS'(header_bytes_r - 3'd1);
        end
      end else if (phase_r != PH_DONE) begin
        zero_run_nxt = zr_step;
        if (esc) begin
          // Dropped byte still costs budget; before the signature ends it
          // also costs payload slack.
          if (raw_zero) begin
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            res_code  = stage_code(phase_r);
          end else begin
            raw_left_nxt = raw_dec;
            if (phase_r == PH_PAY && match_good_r && sig_open) begin
              if (slack_r == '0) begin
                match_good_nxt = 1'b0;
              end else begin
                slack_nxt = slack_r - LEN_BITS'(1);
              end
            end
          end
        end else begin
          case (phase_r)
            PH_HEAD: begin
              skip_nxt = skip_dec;
              if (skip_one) begin
                if (raw_ge9) begin
                  phase_nxt    = PH_TYPE;
                  type_sum_nxt = '0;
                  raw_left_nxt = raw_dec;
                end else begin
                  phase_nxt = PH_DONE;
                  res_valid = 1'b1;
                  res_code  = OUTC_NONE;
                end
              end
            end
            PH_TYPE: begin
              type_sum_nxt = type_new;
              if (b != BYTE_EXT) begin
                phase_nxt    = PH_SIZE;
                size_sum_nxt = '0;
              end
              if (raw_zero) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res_code  = (b == BYTE_EXT) ? OUTC_TYPE_FAIL : OUTC_SIZE_FAIL;
              end else begin
                raw_left_nxt = raw_dec;
              end
            end
            PH_SIZE: begin
              size_sum_nxt = size_new;
              if (b == BYTE_EXT) begin
                if (raw_zero) begin
                  phase_nxt = PH_DONE;
                  res_valid = 1'b1;
                  res_code  = OUTC_SIZE_FAIL;
                end else begin
                  raw_left_nxt = raw_dec;
                end
              end else if (pay_fail) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res_code  = OUTC_PAY_FAIL;
              end else begin
                // Start of the payload skip.
                raw_left_nxt   = pay_diff[LEN_BITS-1:0];
                skip_nxt       = size_new;
                match_pos_nxt  = '0;
                match_good_nxt = type_is_ud && size_ge_sig;
                slack_nxt      = (type_is_ud && size_ge_sig) ? slack_new : '0;
                if (size_new == '0) begin
                  // Empty payload goes straight to the next message.
                  if (raw_ge9) begin
                    phase_nxt    = PH_TYPE;
                    type_sum_nxt = '0;
                    raw_left_nxt = raw_dec;
                  end else begin
                    phase_nxt = PH_DONE;
                    res_valid = 1'b1;
                    res_code  = OUTC_NONE;
                  end
                end else begin
                  phase_nxt = PH_PAY;
                end
              end
            end
            PH_PAY: begin
              match_good_nxt = mg_pay;
              match_pos_nxt  = mp_pay;
              skip_nxt       = skip_dec;
              if (skip_one) begin
                if (type_is_ud && mg_pay && mp_pay == SIG_END) begin
                  phase_nxt = PH_DONE;
                  res_valid = 1'b1;
                  res_code  = OUTC_FOUND;
                end else if (raw_ge9) begin
                  phase_nxt    = PH_TYPE;
                  type_sum_nxt = '0;
                  raw_left_nxt = raw_dec;
                end else begin
                  phase_nxt = PH_DONE;
                  res_valid = 1'b1;
                  res_code  = OUTC_NONE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Data ran out before a decision.
      if (!res_valid && phase_nxt != PH_DONE && in_chan.end_of_data) begin
        res_valid = 1'b1;
        res_code  = stage_code(phase_nxt);
        phase_nxt = PH_DONE;
      end
    end
  end

  assign res.valid          = fire && res_valid;
  assign res.captions_found = res_code == OUTC_FOUND;
  assign res.outcome        = res_code;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r <= HDR_BYTES_RST;
    end else if (cfg_wr_en) begin
      header_bytes_r <= cfg_wr_data;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DONE;
      raw_left_r   <= '0;
      zero_run_r   <= '0;
      skip_r       <= '0;
      type_sum_r   <= '0;
      size_sum_r   <= '0;
      match_pos_r  <= '0;
      match_good_r <= 1'b1;
      slack_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      raw_left_r   <= raw_left_nxt;
      zero_run_r   <= zero_run_nxt;
      skip_r       <= skip_nxt;
      type_sum_r   <= type_sum_nxt;
      size_sum_r   <= size_sum_nxt;
      match_pos_r  <= match_pos_nxt;
      match_good_r <= match_good_nxt;
      slack_r      <= slack_nxt;
    end
  end

endmodule

[hdl/sei_cap_out_stage.sv]
module sei_cap_out_stage import sei_cap_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  sei_cap_result_t res,
  output logic            accept_ok,
  sei_cap_out_if.source   out_chan
);

  logic                 valid_r, valid_nxt;
  logic                 found_r;
  logic [OUTCOME_W-1:0] outcome_r;

  // The parser may run whenever the result register is empty or draining.
  assign accept_ok = !valid_r || out_chan.ready;

  // Result is held until taken; a new result replaces one being taken.
  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      found_r   <= res.captions_found;
      outcome_r <= res.outcome;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.captions_found = found_r;
  assign out_chan.outcome        = outcome_r;

endmodule
